>>> hw/rtl/aet_pkg.sv
// Shared types, codes and default sizes for the adjacency edge table.
`default_nettype none

package aet_pkg;

  localparam int unsigned MaxNodesDef   = 16;
  localparam int unsigned MaxDegreeDef  = 8;
  localparam int unsigned WeightBitsDef = 16;

  localparam int unsigned CfgW           = 5;
  localparam logic [CfgW-1:0] NodeCountRst = 5'd15;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [3:0]  source_node;
    logic [3:0]  dest_node;
    logic [15:0] edge_weight;
    logic        both_directions;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] source_degree;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_SDEG,
    ST_DDEG,
    ST_OP,
    ST_INS_REV,
    ST_SEARCH,
    ST_MOVE,
    ST_RESP
  } aet_state_e;

endpackage

`default_nettype wire

>>> hw/rtl/adjacency_edge_table.sv
// Top level of the adjacency edge table: sequencer, degree memory and slot memory.
`default_nettype none

// One command is taken when start is high and busy is low; busy then stays high
// until the single result has been shown on result_o for one cycle with done_o.
// The receiver cannot stall, so result_o must be captured in that cycle. An
// insert runs the range check, reads both degrees, writes the slot (and the
// reverse slot with both_directions) and gives its result; a node out of range
// goes from the range check straight to the result. A delete scans the source
// list through the one read port of the slot memory, one slot per cycle with a
// single comparator, then moves the last entry into the hole, and does the same
// for the reverse list when both_directions is set. node_count is written over
// the cfg channel, which is always ready; write it only while busy is low.
module adjacency_edge_table import aet_pkg::*; #(
  parameter int unsigned MAX_NODES   = MaxNodesDef,
  parameter int unsigned MAX_DEGREE  = MaxDegreeDef,
  parameter int unsigned WEIGHT_BITS = WeightBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire in_item_t        item_i,
  output      logic            busy,
  output      logic            done_o,
  output      out_item_t       result_o,
  input  wire logic            cfg_valid_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  output      logic            cfg_ready_o
);

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned SLOTS  = MAX_NODES * MAX_DEGREE;
  localparam int unsigned ADDR_W = $clog2(SLOTS);
  localparam int unsigned EDGE_W = NODE_W + WEIGHT_BITS;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [NODE_W-1:0] node,
                                                  input logic [DEG_W-1:0]  slot);
    return ADDR_W'(node) * ADDR_W'(MAX_DEGREE) + ADDR_W'(slot);
  endfunction

  aet_state_e state_q, state_d;
  in_item_t   item_q;
  logic [CfgW-1:0]  node_count_q;
  logic [DEG_W-1:0] sdeg_q, sdeg_d, ddeg_q, ddeg_d;
  logic [DEG_W-1:0] idx_q, idx_d, pidx_q, pidx_d, hole_q, hole_d;
  logic             pend_q, pend_d, rev_q, rev_d;
  status_e          status_q, status_d;

  // degree memory with per-node valid bits
  logic [DEG_W-1:0]  deg_mem_q [MAX_NODES];
  logic [MAX_NODES-1:0] deg_vld_q;
  logic [DEG_W-1:0]  deg_rd_q;
  logic              deg_rvld_q;
  logic              deg_we;
  logic [NODE_W-1:0] deg_waddr, deg_raddr;
  logic [DEG_W-1:0]  deg_wdata, deg_val;

  // slot memory ports
  logic              edge_we;
  logic [ADDR_W-1:0] edge_waddr, edge_raddr;
  logic [EDGE_W-1:0] edge_wdata, edge_rdata;

  logic [NODE_W-1:0] src_n, dst_n, list_node, list_tgt;
  logic [DEG_W-1:0]  list_deg;
  logic [DEG_W:0]    sdeg_p2;
  logic              in_range, same_node, fits, hit, both;

  assign src_n     = NODE_W'(item_q.source_node);
  assign dst_n     = NODE_W'(item_q.dest_node);
  assign both      = item_q.both_directions;
  assign same_node = (src_n == dst_n);

  assign in_range = ({1'b0, item_q.source_node} < node_count_q)
                 && ({1'b0, item_q.dest_node} < node_count_q)
                 && (32'(item_q.source_node) < MAX_NODES)
                 && (32'(item_q.dest_node) < MAX_NODES);

  assign sdeg_p2 = {1'b0, sdeg_q} + (DEG_W+1)'(2);
  assign fits = (both && same_node) ? (sdeg_p2 <= (DEG_W+1)'(MAX_DEGREE))
              : ((sdeg_q < DEG_W'(MAX_DEGREE)) && (!both || (ddeg_q < DEG_W'(MAX_DEGREE))));

  // the list under scan: forward list first, then the reverse one
  assign list_node = rev_q ? dst_n  : src_n;
  assign list_tgt  = rev_q ? src_n  : dst_n;
  assign list_deg  = rev_q ? ddeg_q : sdeg_q;
  assign hit = pend_q && (edge_rdata[EDGE_W-1 -: NODE_W] == list_tgt);

  assign deg_val = deg_rvld_q ? deg_rd_q : '0;

  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (start) state_d = ST_RANGE;
      ST_RANGE:   state_d = in_range ? ST_SDEG : ST_RESP;
      ST_SDEG:    state_d = ST_DDEG;
      ST_DDEG:    state_d = ST_OP;
      ST_OP: begin
        if (item_q.opcode == OP_DELETE) begin
          state_d = ST_SEARCH;
        end else if (fits && both) begin
          state_d = ST_INS_REV;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_INS_REV: state_d = ST_RESP;
      ST_SEARCH: begin
        if (hit) begin
          state_d = ST_MOVE;
        end else if (!pend_q && (idx_q == list_deg)) begin
          state_d = ST_RESP;
        end
      end
      ST_MOVE:    state_d = (!rev_q && both) ? ST_SEARCH : ST_RESP;
      ST_RESP:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    sdeg_d     = sdeg_q;
    ddeg_d     = ddeg_q;
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    hole_d     = hole_q;
    pend_d     = pend_q;
    rev_d      = rev_q;
    status_d   = status_q;
    deg_we     = 1'b0;
    deg_waddr  = src_n;
    deg_wdata  = '0;
    deg_raddr  = src_n;
    edge_we    = 1'b0;
    edge_waddr = '0;
    edge_wdata = {src_n, WEIGHT_BITS'(item_q.edge_weight)};
    edge_raddr = '0;

    busy   = (state_q != ST_IDLE);
    done_o = (state_q == ST_RESP);
    result_o.status        = status_q;
    result_o.source_degree = (status_q == STATUS_RANGE) ? 4'd0 : 4'(sdeg_q);

    case (state_q)
      ST_RANGE: begin
        status_d = in_range ? STATUS_DONE : STATUS_RANGE;
      end
      ST_SDEG: begin
        sdeg_d    = deg_val;
        deg_raddr = dst_n;
      end
      ST_DDEG: begin
        ddeg_d = deg_val;
      end
      ST_OP: begin
        idx_d  = '0;
        pend_d = 1'b0;
        rev_d  = 1'b0;
        if (item_q.opcode == OP_INSERT) begin
          if (!fits) begin
            status_d = STATUS_FULL;
          end else begin
            edge_we    = 1'b1;
            edge_waddr = slot_addr(src_n, sdeg_q);
            edge_wdata = {dst_n, WEIGHT_BITS'(item_q.edge_weight)};
            deg_we     = 1'b1;
            deg_waddr  = src_n;
            deg_wdata  = sdeg_q + DEG_W'(1);
            sdeg_d     = sdeg_q + DEG_W'(1);
            if (same_node) ddeg_d = sdeg_q + DEG_W'(1);
            status_d   = STATUS_DONE;
          end
        end
      end
      ST_INS_REV: begin
        edge_we    = 1'b1;
        edge_waddr = slot_addr(dst_n, ddeg_q);
        edge_wdata = {src_n, WEIGHT_BITS'(item_q.edge_weight)};
        deg_we     = 1'b1;
        deg_waddr  = dst_n;
        deg_wdata  = ddeg_q + DEG_W'(1);
        ddeg_d     = ddeg_q + DEG_W'(1);
        if (same_node) sdeg_d = ddeg_q + DEG_W'(1);
      end
      ST_SEARCH: begin
        if (hit) begin
          // fetch the last entry to fill the hole
          edge_raddr = slot_addr(list_node, list_deg - DEG_W'(1));
          hole_d     = pidx_q;
          pend_d     = 1'b0;
        end else begin
          edge_raddr = slot_addr(list_node, idx_q);
          if (idx_q != list_deg) begin
            pend_d = 1'b1;
            pidx_d = idx_q;
            idx_d  = idx_q + DEG_W'(1);
          end else begin
            pend_d = 1'b0;
          end
          if (!pend_q && (idx_q == list_deg)) begin
            status_d = rev_q ? STATUS_DONE : STATUS_MISSING;
          end
        end
      end
      ST_MOVE: begin
        edge_we    = 1'b1;
        edge_waddr = slot_addr(list_node, hole_q);
        edge_wdata = edge_rdata;
        deg_we     = 1'b1;
        deg_waddr  = list_node;
        deg_wdata  = list_deg - DEG_W'(1);
        if (list_node == src_n) sdeg_d = list_deg - DEG_W'(1);
        if (list_node == dst_n) ddeg_d = list_deg - DEG_W'(1);
        status_d = STATUS_DONE;
        if (!rev_q && both) begin
          rev_d  = 1'b1;
          idx_d  = '0;
          pend_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NodeCountRst;
      pend_q       <= 1'b0;
      rev_q        <= 1'b0;
      status_q     <= STATUS_DONE;
      sdeg_q       <= '0;
      ddeg_q       <= '0;
      idx_q        <= '0;
      pidx_q       <= '0;
      hole_q       <= '0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      rev_q    <= rev_d;
      status_q <= status_d;
      sdeg_q   <= sdeg_d;
      ddeg_q   <= ddeg_d;
      idx_q    <= idx_d;
      pidx_q   <= pidx_d;
      hole_q   <= hole_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem_q[deg_waddr] <= deg_wdata;
    end
    deg_rd_q <= deg_mem_q[deg_raddr];
  end

  // an unwritten node reads as degree zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q  <= '0;
      deg_rvld_q <= 1'b0;
    end else begin
      if (deg_we) begin
        deg_vld_q[deg_waddr] <= 1'b1;
      end
      deg_rvld_q <= deg_vld_q[deg_raddr];
    end
  end

  aet_edge_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (ADDR_W),
    .DATA_W (EDGE_W)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

`ifndef SYNTHESIS
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat outside a command");

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("busy held after the result beat");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted command did not raise busy");

  a_deg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deg_we |-> (32'(deg_wdata) <= MAX_DEGREE))
    else $error("degree written above the list size");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/aet_edge_ram.sv
// Slot memory: one write port, one registered read port.
`default_nettype none

module aet_edge_ram #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned DATA_W = 20
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
